// ----- hdl/ackrt_pkg.sv -----
// ============================================================================
// ackrt_pkg
// shared types and codes for the acknowledgement and retransmit tracker
// ============================================================================
package ackrt_pkg;

    localparam logic [2:0] REQ_SEND      = 3'd0;
    localparam logic [2:0] REQ_FRAME_OK  = 3'd1;
    localparam logic [2:0] REQ_FRAME_ERR = 3'd2;
    localparam logic [2:0] REQ_RECEIVE   = 3'd3;
    localparam logic [2:0] REQ_TICK      = 3'd4;
    localparam logic [2:0] REQ_REFRAME   = 3'd5;

    localparam logic [2:0] KIND_DELIVER  = 3'd0;
    localparam logic [2:0] KIND_SEND_ACK = 3'd1;
    localparam logic [2:0] KIND_DONE     = 3'd2;
    localparam logic [2:0] KIND_FAILED   = 3'd3;
    localparam logic [2:0] KIND_RESEND   = 3'd4;
    localparam logic [2:0] KIND_ACCEPT   = 3'd5;
    localparam logic [2:0] KIND_REJECT   = 3'd6;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd0;
    localparam logic [1:0] ST_BAD_PORT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [2:0] REG_RETRY_DELAY = 3'd0;
    localparam logic [2:0] REG_MAX_RETRIES = 3'd1;
    localparam logic [2:0] REG_MARGIN      = 3'd2;
    localparam logic [2:0] REG_MAX_DATA    = 3'd3;
    localparam logic [2:0] REG_HEADER      = 3'd4;

    localparam logic [4:0] RETRY_SAT = 5'd31;
    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  segment;
        logic [15:0] frame;
        logic [15:0] peer;
        logic        ack_req;
        logic [5:0]  port;
        logic [4:0]  retries;
        logic [31:0] deadline;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [5:0]  port;
        logic [7:0]  segment;
        logic [15:0] peer;
        logic        ack;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SCAN, S_LAST, S_FETCH, S_ACT, S_ARM, S_WR5, S_EMIT0, S_EMIT1
    } t_state;

endpackage

// ----- hdl/ack_retransmit_tracker.sv -----
// ============================================================================
// ack_retransmit_tracker
// outstanding segment table with backoff timers and duplicate filtering
// ============================================================================
// One request is taken when start is high and busy is low; busy stays high
// until its results are out. Sends and receives that need no acknowledgement
// match emit their results straight after the request is decoded, and resend
// frame updates write the slot after decoding. Frame reports, acknowledgement
// matches and ticks scan the slot table through its single read port, one slot
// a cycle, then fetch the chosen slot and act on it, re-arming a timer in a
// further step. Results appear for one cycle each under o_res_valid, at most
// two per request, and cannot be held off.
module ack_retransmit_tracker #(
    parameter int TX_SLOTS   = 8,
    parameter int SEEN_DEPTH = 16,
    parameter int MAX_PORT   = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_segment_id,
    input  logic [15:0] i_frame_id,
    input  logic [15:0] i_peer_address,
    input  logic [5:0]  i_port,
    input  logic        i_ack_requested,
    input  logic        i_ack_response,
    input  logic [7:0]  i_length,
    input  logic [2:0]  i_slot_index,
    output logic        o_res_valid,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_index_out,
    output logic [5:0]  o_port_out,
    output logic [7:0]  o_segment_id_out,
    output logic [15:0] o_peer_address_out,
    output logic        o_ack_flag_out,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ackrt_pkg::*;

    localparam int IW = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
    localparam int CW = $clog2(TX_SLOTS + 1);
    localparam int SW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

    t_state r_state, n_state;

    logic [15:0] r_retry_delay;
    logic [3:0]  r_max_retries;
    logic [7:0]  r_margin;
    logic [7:0]  r_max_data;
    logic [3:0]  r_header;

    logic [2:0]  r_req;
    logic [7:0]  r_seg;
    logic [15:0] r_frame;
    logic [15:0] r_peer;
    logic [5:0]  r_port;
    logic        r_ackreq;
    logic        r_ackresp;
    logic [7:0]  r_len;
    logic [2:0]  r_sidx;

    logic          r_valid [TX_SLOTS];
    logic [IW-1:0] r_age   [TX_SLOTS];
    logic          r_wait  [TX_SLOTS];
    logic [8:0]    r_seen  [SEEN_DEPTH];
    logic [SW-1:0] r_seen_ptr;
    logic [31:0]   r_now;

    logic [IW-1:0] r_scan_idx;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [47:0]   r_sum;

    t_result     r_res0, r_res1;
    logic [1:0]  r_nres;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_entry        rd;

    ackrt_slot_mem #(.DEPTH(TX_SLOTS), .AW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    // free slot and occupancy
    logic          free_ok;
    logic [IW-1:0] free_idx;
    logic [CW-1:0] count;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        count    = '0;
        for (int i = TX_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
            count = count + CW'(r_valid[i]);
        end
    end

    logic dup;
    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < SEEN_DEPTH; i++) begin
            if (r_seen[i] == {1'b1, r_seg}) dup = 1'b1;
        end
    end

    logic sidx_ok;
    logic [IW-1:0] sidx_w;
    assign sidx_ok = (32'(r_sidx) < TX_SLOTS) && r_valid[IW'(r_sidx)];
    assign sidx_w  = IW'(r_sidx);

    logic len_long, port_bad, len_short;
    assign len_long  = r_len > r_max_data;
    assign port_bad  = 32'(r_port) > MAX_PORT;
    assign len_short = r_len < {4'd0, r_header};

    // scan compare on read data
    logic hit, better;
    always_comb begin
        case (r_req)
            REQ_FRAME_OK, REQ_FRAME_ERR: hit = rd.frame == r_frame;
            REQ_RECEIVE:                 hit = rd.segment == r_seg;
            REQ_TICK:                    hit = r_wait[r_chk_idx] && (r_now >= rd.deadline);
            default:                     hit = 1'b0;
        endcase
        hit    = hit && r_valid[r_chk_idx] && r_chk;
        better = !r_found || (r_age[r_chk_idx] < r_age[r_best]);
    end

    logic [47:0] t_arm;
    logic [31:0] deadline;
    always_comb begin
        t_arm = (r_sum >= {40'd0, r_margin}) ? r_sum - {40'd0, r_margin} : 48'd0;
        deadline = (t_arm > {16'd0, TICK_MAX}) ? TICK_MAX : t_arm[31:0];
    end

    // decisions in the act state
    logic act_remove, act_arm;
    t_result act_res;
    always_comb begin
        act_remove = 1'b0;
        act_arm    = 1'b0;
        act_res    = '0;
        act_res.port = rd.port;
        case (r_req)
            REQ_FRAME_OK, REQ_FRAME_ERR: begin
                if (!rd.ack_req) begin
                    act_remove   = 1'b1;
                    act_res.kind = (r_req == REQ_FRAME_OK) ? KIND_DONE : KIND_FAILED;
                end else if (r_req == REQ_FRAME_ERR && rd.retries >= {1'b0, r_max_retries}) begin
                    act_remove   = 1'b1;
                    act_res.kind = KIND_FAILED;
                end else begin
                    act_arm = 1'b1;
                end
            end
            REQ_RECEIVE: begin
                act_remove   = 1'b1;
                act_res.kind = KIND_DONE;
            end
            REQ_TICK: begin
                if (rd.retries > {1'b0, r_max_retries}) begin
                    act_remove   = 1'b1;
                    act_res.kind = KIND_FAILED;
                end else begin
                    act_res.kind    = KIND_RESEND;
                    act_res.slot    = 3'(r_best);
                    act_res.segment = rd.segment;
                    act_res.peer    = rd.peer;
                    act_res.ack     = rd.ack_req;
                end
            end
            default: act_res = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_EXEC;
            S_EXEC: begin
                case (r_req)
                    REQ_SEND:                    n_state = S_EMIT0;
                    REQ_FRAME_OK, REQ_FRAME_ERR,
                    REQ_TICK:                    n_state = S_SCAN;
                    REQ_RECEIVE: begin
                        if (len_short)         n_state = S_IDLE;
                        else if (r_ackresp)    n_state = S_SCAN;
                        else if (r_ackreq || !dup) n_state = S_EMIT0;
                        else                   n_state = S_IDLE;
                    end
                    REQ_REFRAME: n_state = sidx_ok ? S_WR5 : S_IDLE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_SCAN:  if (r_scan_idx == IW'(TX_SLOTS - 1)) n_state = S_LAST;
            S_LAST:  n_state = S_FETCH;
            S_FETCH: begin
                if (r_found)             n_state = S_ACT;
                else if (r_nres != 2'd0) n_state = S_EMIT0;
                else                     n_state = S_IDLE;
            end
            S_ACT:   n_state = act_arm ? S_ARM : S_EMIT0;
            S_ARM:   n_state = S_IDLE;
            S_WR5:   n_state = S_IDLE;
            S_EMIT0: n_state = (r_nres == 2'd2) ? S_EMIT1 : S_IDLE;
            S_EMIT1: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_best;
        mem_wdata = rd;
        mem_raddr = r_best;
        case (r_state)
            S_EXEC: begin
                mem_raddr = sidx_w;
                if (r_req == REQ_SEND) begin
                    mem_we    = !len_long && !port_bad && free_ok;
                    mem_waddr = free_idx;
                    mem_wdata = '{segment: r_seg, frame: r_frame, peer: r_peer,
                                  ack_req: r_ackreq, port: r_port,
                                  retries: 5'd0, deadline: 32'd0};
                end
            end
            S_SCAN: mem_raddr = r_scan_idx;
            S_ARM: begin
                mem_we             = 1'b1;
                mem_wdata.deadline = deadline;
                mem_wdata.retries  = (rd.retries == RETRY_SAT) ? RETRY_SAT : rd.retries + 5'd1;
            end
            S_WR5: begin
                mem_we          = 1'b1;
                mem_waddr       = sidx_w;
                mem_wdata.frame = r_frame;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // outputs
    always_comb begin
        busy        = r_state != S_IDLE;
        o_res_valid = (r_state == S_EMIT0) || (r_state == S_EMIT1);
        o_last      = (r_state == S_EMIT1) || (r_state == S_EMIT0 && r_nres == 2'd1);
        o_kind             = (r_state == S_EMIT1) ? r_res1.kind    : r_res0.kind;
        o_status           = (r_state == S_EMIT1) ? r_res1.status  : r_res0.status;
        o_slot_index_out   = (r_state == S_EMIT1) ? r_res1.slot    : r_res0.slot;
        o_port_out         = (r_state == S_EMIT1) ? r_res1.port    : r_res0.port;
        o_segment_id_out   = (r_state == S_EMIT1) ? r_res1.segment : r_res0.segment;
        o_peer_address_out = (r_state == S_EMIT1) ? r_res1.peer    : r_res0.peer;
        o_ack_flag_out     = (r_state == S_EMIT1) ? r_res1.ack     : r_res0.ack;
        pready = 1'b1;
        case (paddr[4:2])
            REG_RETRY_DELAY: prdata = {16'd0, r_retry_delay};
            REG_MAX_RETRIES: prdata = {28'd0, r_max_retries};
            REG_MARGIN:      prdata = {24'd0, r_margin};
            REG_MAX_DATA:    prdata = {24'd0, r_max_data};
            REG_HEADER:      prdata = {28'd0, r_header};
            default:         prdata = 32'd0;
        endcase
    end

    // input capture and scan payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req     <= i_req_type;
            r_seg     <= i_segment_id;
            r_frame   <= i_frame_id;
            r_peer    <= i_peer_address;
            r_port    <= i_port;
            r_ackreq  <= i_ack_requested;
            r_ackresp <= i_ack_response;
            r_len     <= i_length;
            r_sidx    <= i_slot_index;
        end
        r_chk_idx <= r_scan_idx;
        if (r_state == S_ACT) begin
            r_sum <= {16'd0, r_now} + ({32'd0, r_retry_delay} << rd.retries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_retry_delay <= 16'd1000;
            r_max_retries <= 4'd3;
            r_margin      <= 8'd5;
            r_max_data    <= 8'd200;
            r_header      <= 4'd4;
            for (int i = 0; i < TX_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
                r_wait[i]  <= 1'b0;
            end
            for (int i = 0; i < SEEN_DEPTH; i++) r_seen[i] <= 9'd0;
            r_seen_ptr <= '0;
            r_now      <= 32'd0;
            r_scan_idx <= '0;
            r_chk      <= 1'b0;
            r_found    <= 1'b0;
            r_best     <= '0;
            r_nres     <= 2'd0;
            r_res0     <= '0;
            r_res1     <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_RETRY_DELAY: r_retry_delay <= pwdata[15:0];
                    REG_MAX_RETRIES: r_max_retries <= pwdata[3:0];
                    REG_MARGIN:      r_margin      <= pwdata[7:0];
                    REG_MAX_DATA:    r_max_data    <= pwdata[7:0];
                    REG_HEADER:      r_header      <= pwdata[3:0];
                    default:         r_header      <= r_header;
                endcase
            end

            r_chk <= r_state == S_SCAN;
            if (hit && better) begin
                r_found <= 1'b1;
                r_best  <= r_chk_idx;
            end
            if (r_state == S_SCAN && r_scan_idx != IW'(TX_SLOTS - 1)) begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end

            case (r_state)
                S_EXEC: begin
                    r_scan_idx <= '0;
                    r_found    <= 1'b0;
                    case (r_req)
                        REQ_SEND: begin
                            r_nres <= 2'd1;
                            if (len_long) begin
                                r_res0 <= '{kind: KIND_REJECT, status: ST_TOO_LONG, default: '0};
                            end else if (port_bad) begin
                                r_res0 <= '{kind: KIND_REJECT, status: ST_BAD_PORT, default: '0};
                            end else if (!free_ok) begin
                                r_res0 <= '{kind: KIND_REJECT, status: ST_FULL, default: '0};
                            end else begin
                                r_res0 <= '{kind: KIND_ACCEPT, status: ST_NONE,
                                            slot: 3'(free_idx), default: '0};
                                r_valid[free_idx] <= 1'b1;
                                r_age[free_idx]   <= IW'(count);
                                r_wait[free_idx]  <= 1'b0;
                            end
                        end
                        REQ_RECEIVE: begin
                            if (len_short) begin
                                r_nres <= 2'd0;
                            end else begin
                                if (r_ackreq) begin
                                    r_res0 <= '{kind: KIND_SEND_ACK, port: r_port,
                                                segment: r_seg, peer: r_peer, default: '0};
                                end else if (!r_ackresp && !dup) begin
                                    r_res0 <= '{kind: KIND_DELIVER, port: r_port,
                                                segment: r_seg, peer: r_peer, default: '0};
                                end
                                if (!r_ackresp && !dup) begin
                                    r_seen[r_seen_ptr] <= {1'b1, r_seg};
                                    r_seen_ptr <= (r_seen_ptr == SW'(SEEN_DEPTH - 1)) ?
                                                  '0 : r_seen_ptr + SW'(1);
                                    if (r_ackreq) begin
                                        r_res1 <= '{kind: KIND_DELIVER, port: r_port,
                                                    segment: r_seg, peer: r_peer, default: '0};
                                        r_nres <= 2'd2;
                                    end else begin
                                        r_nres <= 2'd1;
                                    end
                                end else begin
                                    r_nres <= {1'b0, r_ackreq};
                                end
                            end
                        end
                        REQ_TICK: begin
                            r_nres <= 2'd0;
                            if (r_now != TICK_MAX) r_now <= r_now + 32'd1;
                        end
                        default: r_nres <= 2'd0;
                    endcase
                end
                S_ACT: begin
                    if (act_remove) begin
                        r_valid[r_best] <= 1'b0;
                        r_wait[r_best]  <= 1'b0;
                        for (int i = 0; i < TX_SLOTS; i++) begin
                            if (r_valid[i] && r_age[i] > r_age[r_best]) begin
                                r_age[i] <= r_age[i] - IW'(1);
                            end
                        end
                    end else if (!act_arm) begin
                        r_wait[r_best] <= 1'b0;
                    end
                    if (!act_arm) begin
                        if (r_nres == 2'd0) r_res0 <= act_res;
                        else                r_res1 <= act_res;
                        r_nres <= r_nres + 2'd1;
                    end
                end
                S_ARM: r_wait[r_best] <= 1'b1;
                default: r_nres <= r_nres;
            endcase
        end
    end
endmodule

// ----- hdl/ackrt_slot_mem.sv -----
// ============================================================================
// ackrt_slot_mem
// slot table storage, one write port and one registered read port
// ============================================================================
module ackrt_slot_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  ackrt_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output ackrt_pkg::t_entry     o_rdata
);
    import ackrt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- verif/ack_retransmit_tracker_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// ack_retransmit_tracker_test
// self-checking test of the outstanding segment tracker through its request
// port, with its own predictor of the slot table, backoff timers and
// duplicate ring, and register writes over the configuration port
// ============================================================================
module ack_retransmit_tracker_test;
    import ackrt_pkg::*;

    localparam int NSLOT = 8;
    localparam int NSEEN = 16;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  req;
        logic [7:0]  seg;
        logic [15:0] frame;
        logic [15:0] peer;
        logic [5:0]  port;
        logic        ackreq;
        logic        ackresp;
        logic [7:0]  len;
        logic [2:0]  sidx;
    } t_req;

    typedef struct {
        t_result res;
        logic    last;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_req_type = '0;
    logic [7:0] i_segment_id = '0;
    logic [15:0] i_frame_id = '0;
    logic [15:0] i_peer_address = '0;
    logic [5:0] i_port = '0;
    logic i_ack_requested = 1'b0;
    logic i_ack_response = 1'b0;
    logic [7:0] i_length = '0;
    logic [2:0] i_slot_index = '0;
    logic o_res_valid;
    logic [2:0] o_kind;
    logic [1:0] o_status;
    logic [2:0] o_slot_index_out;
    logic [5:0] o_port_out;
    logic [7:0] o_segment_id_out;
    logic [15:0] o_peer_address_out;
    logic o_ack_flag_out;
    logic o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ack_retransmit_tracker dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [15:0] cfg_delay;
    logic [3:0]  cfg_retries;
    logic [7:0]  cfg_margin;
    logic [7:0]  cfg_max_data;
    logic [3:0]  cfg_header;
    logic        tb_valid [NSLOT];
    int          tb_age [NSLOT];
    logic [7:0]  tb_seg [NSLOT];
    logic [15:0] tb_frame [NSLOT];
    logic [15:0] tb_peer [NSLOT];
    logic [5:0]  tb_port [NSLOT];
    logic        tb_ackreq [NSLOT];
    logic        tb_waiting [NSLOT];
    logic [4:0]  tb_retries [NSLOT];
    logic [31:0] tb_deadline [NSLOT];
    logic [8:0]  seen_ring [NSEEN];
    int          seen_ptr;
    logic [31:0] ticks_now;

    t_req     pending_reqs[$];
    t_outcome expected_results[$];
    int  mismatches = 0;
    int  transfers_in = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    bit  hold_sender = 1'b0;
    bit  in_taken = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic void queue_req(t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void predictor_reset();
        cfg_delay = 16'd1000; cfg_retries = 4'd3; cfg_margin = 8'd5;
        cfg_max_data = 8'd200; cfg_header = 4'd4;
        for (int i = 0; i < NSLOT; i++) begin
            tb_valid[i] = '0; tb_age[i] = 0; tb_waiting[i] = '0;
            tb_seg[i] = '0; tb_frame[i] = '0; tb_peer[i] = '0; tb_port[i] = '0;
            tb_ackreq[i] = '0; tb_retries[i] = '0; tb_deadline[i] = '0;
        end
        for (int i = 0; i < NSEEN; i++) seen_ring[i] = '0;
        seen_ptr = 0;
        ticks_now = '0;
    endfunction

    function automatic int occupied();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (tb_valid[i]) n++;
        return n;
    endfunction

    function automatic int slot_of_rank(int r);
        for (int i = 0; i < NSLOT; i++) if (tb_valid[i] && tb_age[i] == r) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int s);
        int a;
        a = tb_age[s];
        tb_valid[s] = 1'b0; tb_waiting[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++) if (tb_valid[i] && tb_age[i] > a) tb_age[i]--;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [1:0] st, logic [2:0] sl,
                                        logic [5:0] p, logic [7:0] sg, logic [15:0] pr,
                                        logic ak);
        t_outcome o;
        o.res.kind = kind; o.res.status = st; o.res.slot = sl; o.res.port = p;
        o.res.segment = sg; o.res.peer = pr; o.res.ack = ak; o.last = 1'b1;
        if (expected_results.size() > 0 && expected_results[$].last === 1'bx)
            expected_results[$].last = 1'b0;
        expected_results.insert(expected_results.size(), o);
    endfunction

    function automatic void arm_timer(int s);
        logic [63:0] t;
        t = {32'd0, ticks_now} + ({48'd0, cfg_delay} << tb_retries[s]);
        t = (t >= cfg_margin) ? t - cfg_margin : 64'd0;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        tb_deadline[s] = t[31:0];
        tb_waiting[s] = 1'b1;
        if (tb_retries[s] < RETRY_SAT) tb_retries[s]++;
    endfunction

    // expected results of one accepted request, marked last on the final one
    function automatic void predict_request(t_req r);
        int s, n, first;
        bit dup;
        first = expected_results.size();
        s = -1;
        case (r.req)
            REQ_SEND: begin
                if (r.len > cfg_max_data) begin
                    push_result(KIND_REJECT, ST_TOO_LONG, '0, '0, '0, '0, '0);
                end else begin
                    for (int i = 0; i < NSLOT; i++) if (!tb_valid[i] && s < 0) s = i;
                    if (s < 0) begin
                        push_result(KIND_REJECT, ST_FULL, '0, '0, '0, '0, '0);
                    end else begin
                        tb_age[s] = occupied(); tb_valid[s] = 1'b1;
                        tb_seg[s] = r.seg; tb_frame[s] = r.frame; tb_peer[s] = r.peer;
                        tb_port[s] = r.port; tb_ackreq[s] = r.ackreq;
                        tb_waiting[s] = 1'b0; tb_retries[s] = '0; tb_deadline[s] = '0;
                        push_result(KIND_ACCEPT, ST_NONE, s[2:0], '0, '0, '0, '0);
                    end
                end
            end
            REQ_FRAME_OK, REQ_FRAME_ERR: begin
                n = occupied();
                for (int k = 0; k < n && s < 0; k++) begin
                    int c;
                    c = slot_of_rank(k);
                    if (c >= 0 && tb_frame[c] == r.frame) s = c;
                end
                if (s >= 0) begin
                    if (!tb_ackreq[s]) begin
                        drop_slot(s);
                        push_result(r.req == REQ_FRAME_OK ? KIND_DONE : KIND_FAILED,
                                    ST_NONE, '0, tb_port[s], '0, '0, '0);
                    end else if (r.req == REQ_FRAME_ERR && tb_retries[s] >= cfg_retries) begin
                        drop_slot(s);
                        push_result(KIND_FAILED, ST_NONE, '0, tb_port[s], '0, '0, '0);
                    end else begin
                        arm_timer(s);
                    end
                end
            end
            REQ_RECEIVE: begin
                if (r.len >= cfg_header) begin
                    if (r.ackreq)
                        push_result(KIND_SEND_ACK, ST_NONE, '0, r.port, r.seg, r.peer, '0);
                    if (r.ackresp) begin
                        n = occupied();
                        for (int k = 0; k < n && s < 0; k++) begin
                            int c;
                            c = slot_of_rank(k);
                            if (c >= 0 && tb_seg[c] == r.seg) s = c;
                        end
                        if (s >= 0) begin
                            drop_slot(s);
                            push_result(KIND_DONE, ST_NONE, '0, tb_port[s], '0, '0, '0);
                        end
                    end else begin
                        dup = 0;
                        for (int i = 0; i < NSEEN; i++) if (seen_ring[i] == {1'b1, r.seg}) dup = 1;
                        if (!dup) begin
                            seen_ring[seen_ptr] = {1'b1, r.seg};
                            seen_ptr = (seen_ptr + 1) % NSEEN;
                            push_result(KIND_DELIVER, ST_NONE, '0, r.port, r.seg, r.peer, '0);
                        end
                    end
                end
            end
            REQ_TICK: begin
                if (ticks_now != TICK_MAX) ticks_now++;
                n = occupied();
                for (int k = 0; k < n; k++) begin
                    int c;
                    c = slot_of_rank(k);
                    if (c >= 0 && tb_waiting[c] && ticks_now >= tb_deadline[c]) begin
                        if (tb_retries[c] > cfg_retries) begin
                            drop_slot(c);
                            push_result(KIND_FAILED, ST_NONE, '0, tb_port[c], '0, '0, '0);
                        end else begin
                            tb_waiting[c] = 1'b0;
                            push_result(KIND_RESEND, ST_NONE, c[2:0], tb_port[c], tb_seg[c],
                                        tb_peer[c], tb_ackreq[c]);
                        end
                        break;
                    end
                end
            end
            REQ_REFRAME: if (tb_valid[r.sidx]) tb_frame[r.sidx] = r.frame;
            default: ;
        endcase
        // results of one request: all but the final one are not last
        for (int i = first; i < expected_results.size() - 1; i++)
            expected_results[i].last = 1'b0;
    endfunction

    function automatic t_req rand_req(logic [2:0] req);
        t_req r;
        r.req = req; r.seg = 8'($urandom); r.frame = 16'($urandom);
        r.peer = 16'($urandom); r.port = 6'($urandom); r.ackreq = 1'($urandom);
        r.ackresp = 1'($urandom); r.len = 8'($urandom); r.sidx = 3'($urandom);
        return r;
    endfunction

    // driver: one item per transfer, random gap before each
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && in_taken) begin
                start <= 1'b0;
                gap_left <= $urandom_range(0, 17);
            end else if (!start && pending_reqs.size() > 0 &&
                         !(hold_sender && (busy || expected_results.size() > 0))) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    i_req_type <= r.req; i_segment_id <= r.seg; i_frame_id <= r.frame;
                    i_peer_address <= r.peer; i_port <= r.port;
                    i_ack_requested <= r.ackreq; i_ack_response <= r.ackresp;
                    i_length <= r.len; i_slot_index <= r.sidx;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor: predicts on accepted requests, checks every result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= start && !busy;
            if ((start && !busy) || o_res_valid) idle_cycles <= 0;
            else                                 idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                t_req r;
                r.req = i_req_type; r.seg = i_segment_id; r.frame = i_frame_id;
                r.peer = i_peer_address; r.port = i_port; r.ackreq = i_ack_requested;
                r.ackresp = i_ack_response; r.len = i_length; r.sidx = i_slot_index;
                predict_request(r);
                transfers_in <= transfers_in + 1;
            end
            if (o_res_valid) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d", o_kind));
                end else begin
                    t_outcome e;
                    e = expected_results.pop_front();
                    if (o_kind !== e.res.kind || o_status !== e.res.status ||
                        o_slot_index_out !== e.res.slot || o_port_out !== e.res.port ||
                        o_segment_id_out !== e.res.segment ||
                        o_peer_address_out !== e.res.peer ||
                        o_ack_flag_out !== e.res.ack || o_last !== e.last)
                        report_mismatch($sformatf({
                            "got k%0d s%0d sl%0d p%0d sg%0d pr%0h a%0d l%0d ",
                            "exp k%0d s%0d sl%0d p%0d sg%0d pr%0h a%0d l%0d"},
                            o_kind, o_status, o_slot_index_out, o_port_out, o_segment_id_out,
                            o_peer_address_out, o_ack_flag_out, o_last, e.res.kind,
                            e.res.status, e.res.slot, e.res.port, e.res.segment, e.res.peer,
                            e.res.ack, e.last));
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RETRY_DELAY: cfg_delay = value[15:0];
            REG_MAX_RETRIES: cfg_retries = value[3:0];
            REG_MARGIN:      cfg_margin = value[7:0];
            REG_MAX_DATA:    cfg_max_data = value[7:0];
            REG_HEADER:      cfg_header = value[3:0];
            default: ;
        endcase
    endtask

    task automatic add_directed();
        t_req r;
        r = rand_req(REQ_SEND); r.len = 8'd255; queue_req(r);
        r = rand_req(REQ_SEND); r.len = 8'd0; r.port = 6'd63; r.ackreq = 1;
        r.frame = 16'hFFFF; r.seg = 8'hFF; r.peer = 16'hFFFF; queue_req(r);
        r = rand_req(REQ_SEND); r.len = 8'd1; r.port = 6'd0; r.ackreq = 0;
        r.frame = 16'h0000; r.seg = 8'h00; r.peer = 16'h0000; queue_req(r);
        r = rand_req(REQ_SEND); r.len = 8'd2; r.ackreq = 1; r.frame = 16'hFFFF;
        r.seg = 8'h11; queue_req(r);
        r = rand_req(REQ_FRAME_OK); r.frame = 16'h1234; queue_req(r);
        r = rand_req(REQ_FRAME_OK); r.frame = 16'h0000; queue_req(r);
        r = rand_req(REQ_FRAME_OK); r.frame = 16'hFFFF; queue_req(r);
        r = rand_req(REQ_FRAME_ERR); r.frame = 16'hFFFF; queue_req(r);
        r = rand_req(REQ_RECEIVE); r.len = 8'd3; queue_req(r);
        r = rand_req(REQ_RECEIVE); r.len = 8'd4; r.ackreq = 1; r.ackresp = 0;
        r.seg = 8'h42; queue_req(r);
        r = rand_req(REQ_RECEIVE); r.len = 8'd9; r.ackreq = 0; r.ackresp = 0;
        r.seg = 8'h42; queue_req(r);
        r = rand_req(REQ_RECEIVE); r.len = 8'd9; r.ackreq = 1; r.ackresp = 1;
        r.seg = 8'h11; queue_req(r);
        r = rand_req(REQ_RECEIVE); r.len = 8'd9; r.ackreq = 0; r.ackresp = 1;
        r.seg = 8'h99; queue_req(r);
        r = rand_req(REQ_REFRAME); r.sidx = 3'd0; r.frame = 16'h0777; queue_req(r);
        r = rand_req(REQ_REFRAME); r.sidx = 3'd7; queue_req(r);
        r = rand_req(3'd6); queue_req(r);
        r = rand_req(3'd7); queue_req(r);
        r = rand_req(REQ_TICK); queue_req(r);
        for (int i = 0; i < 7; i++) begin
            r = rand_req(REQ_SEND); r.len = 8'd10; queue_req(r);
        end
    endtask

    // well-formed exchanges mostly: send, frame report, ticks, resend, ack
    task automatic add_random(int count);
        t_req r;
        logic [7:0] segs [NSLOT];
        logic [15:0] frames [NSLOT];
        int k;
        for (int i = 0; i < NSLOT; i++) begin
            segs[i] = 8'($urandom); frames[i] = 16'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, NSLOT - 1);
            case ($urandom_range(0, 11))
                0, 1: begin
                    r = rand_req(REQ_SEND);
                    r.len = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 60));
                    segs[k] = r.seg; frames[k] = r.frame;
                end
                2, 3: begin
                    r = rand_req($urandom_range(0, 3) == 0 ? REQ_FRAME_ERR : REQ_FRAME_OK);
                    r.frame = $urandom_range(0, 7) == 0 ? 16'($urandom) : frames[k];
                end
                4, 5, 6: r = rand_req(REQ_TICK);
                7: begin
                    r = rand_req(REQ_REFRAME); r.sidx = 3'(k);
                    frames[k] = r.frame;
                end
                8, 9: begin
                    r = rand_req(REQ_RECEIVE); r.ackresp = 1;
                    r.seg = $urandom_range(0, 3) == 0 ? 8'($urandom) : segs[k];
                    r.len = 8'($urandom_range(0, 20));
                end
                10: begin
                    r = rand_req(REQ_RECEIVE); r.ackresp = 0;
                    r.seg = 8'($urandom_range(0, 40));
                end
                default: r = rand_req(3'($urandom_range(0, 7)));
            endcase
            queue_req(r);
        end
    endtask

    initial begin
        predictor_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_directed();
        wait_drained();

        // short waits so timers expire within a few ticks
        write_reg(REG_RETRY_DELAY, 32'd1);
        write_reg(REG_MAX_RETRIES, 32'd0);
        write_reg(REG_MARGIN, 32'd0);
        write_reg(REG_MAX_DATA, 32'd255);
        write_reg(REG_HEADER, 32'd0);
        add_random(300);
        wait_drained();

        write_reg(REG_RETRY_DELAY, 32'd2);
        write_reg(REG_MAX_RETRIES, 32'd15);
        write_reg(REG_MARGIN, 32'd255);
        write_reg(REG_MAX_DATA, 32'd0);
        write_reg(REG_HEADER, 32'd15);
        add_random(300);
        hold_sender = 1'b1;
        wait_drained();
        hold_sender = 1'b0;

        // large delay shifted by many retries reaches saturation
        write_reg(REG_RETRY_DELAY, 32'd65535);
        write_reg(REG_MAX_RETRIES, 32'd15);
        write_reg(REG_MARGIN, 32'd7);
        write_reg(REG_MAX_DATA, 32'd100);
        write_reg(REG_HEADER, 32'd4);
        add_random(300);
        wait_drained();

        write_reg(REG_RETRY_DELAY, 32'd3);
        write_reg(REG_MAX_RETRIES, 32'd2);
        write_reg(REG_MARGIN, 32'd1);
        write_reg(REG_MAX_DATA, 32'd200);
        write_reg(REG_HEADER, 32'd2);
        add_random(600);
        wait_drained();

        $display("%0d requests accepted, %0d results checked over five register settings",
                 transfers_in, results_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/ackrt_pkg.sv
hdl/ackrt_slot_mem.sv
hdl/ack_retransmit_tracker.sv
verif/ack_retransmit_tracker_test.sv
